// ----- hw/rtl/yosd_pkg.sv -----
// ---------------------------------------------------------------------------
// yosd_pkg
// Shared types and constants for the yaw oscillation spin detector: payload
// structs, configuration register indexes, reset values and phase codes.
// ---------------------------------------------------------------------------
package yosd_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_SAMPLE_PERIOD   = 3'd0,
        CFG_BIG_THRESHOLD   = 3'd1,
        CFG_SMALL_THRESHOLD = 3'd2,
        CFG_SHORT_TIMEOUT   = 3'd3,
        CFG_LONG_TIMEOUT    = 3'd4,
        CFG_LOST_LIMIT      = 3'd5,
        CFG_CONFIRM_COUNT   = 3'd6
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_SAMPLE_PERIOD   = 16'd30;
    localparam logic [15:0] RST_BIG_THRESHOLD   = 16'd120;
    localparam logic [15:0] RST_SMALL_THRESHOLD = 16'd30;
    localparam logic [15:0] RST_SHORT_TIMEOUT   = 16'd200;
    localparam logic [15:0] RST_LONG_TIMEOUT    = 16'd5000;
    localparam logic [15:0] RST_LOST_LIMIT      = 16'd1000;
    localparam logic [3:0]  RST_CONFIRM_COUNT   = 4'd3;

    // Saturation limits of the narrow counters
    localparam logic [15:0] LOST_MAX    = 16'hFFFF;
    localparam logic [3:0]  CONFIRM_MAX = 4'hF;

    // Detection phase codes
    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_POS_SWING  = 3'd1,
        PH_POS_SECOND = 3'd2,
        PH_NEG_SWING  = 3'd3,
        PH_NEG_SECOND = 3'd4,
        PH_SPIN       = 3'd5
    } phase_t;

    // Configuration register set
    typedef struct packed {
        logic [15:0] sample_period;
        logic [15:0] big_threshold;
        logic [15:0] small_threshold;
        logic [15:0] short_timeout;
        logic [15:0] long_timeout;
        logic [15:0] lost_limit;
        logic [3:0]  confirm_count;
    } cfg_t;

    // Input transaction
    typedef struct packed {
        logic               enable;
        logic               target_seen;
        logic signed [31:0] yaw_angle;
    } item_t;

    // Result transaction
    typedef struct packed {
        logic [2:0] phase;
        logic       spinning;
        logic       target_lost;
    } result_t;

endpackage

// ----- hw/rtl/yosd_cfg.sv -----
// ---------------------------------------------------------------------------
// yosd_cfg
// Configuration register file. Takes one register write per cycle and
// presents the full register set as a struct.
// ---------------------------------------------------------------------------
module yosd_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output yosd_pkg::cfg_t      cfg
);

    yosd_pkg::cfg_t cfg_reg;
    yosd_pkg::cfg_t cfg_next;

    // Always ready for a write
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the written register
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (yosd_pkg::cfg_index_t'(cfg_index))
                yosd_pkg::CFG_SAMPLE_PERIOD:   cfg_next.sample_period   = cfg_data;
                yosd_pkg::CFG_BIG_THRESHOLD:   cfg_next.big_threshold   = cfg_data;
                yosd_pkg::CFG_SMALL_THRESHOLD: cfg_next.small_threshold = cfg_data;
                yosd_pkg::CFG_SHORT_TIMEOUT:   cfg_next.short_timeout   = cfg_data;
                yosd_pkg::CFG_LONG_TIMEOUT:    cfg_next.long_timeout    = cfg_data;
                yosd_pkg::CFG_LOST_LIMIT:      cfg_next.lost_limit      = cfg_data;
                yosd_pkg::CFG_CONFIRM_COUNT:   cfg_next.confirm_count   = cfg_data[3:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_period   <= yosd_pkg::RST_SAMPLE_PERIOD;
            cfg_reg.big_threshold   <= yosd_pkg::RST_BIG_THRESHOLD;
            cfg_reg.small_threshold <= yosd_pkg::RST_SMALL_THRESHOLD;
            cfg_reg.short_timeout   <= yosd_pkg::RST_SHORT_TIMEOUT;
            cfg_reg.long_timeout    <= yosd_pkg::RST_LONG_TIMEOUT;
            cfg_reg.lost_limit      <= yosd_pkg::RST_LOST_LIMIT;
            cfg_reg.confirm_count   <= yosd_pkg::RST_CONFIRM_COUNT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/yosd_track.sv -----
// ---------------------------------------------------------------------------
// yosd_track
// Detector state and its next-state update: tick and lost counters,
// sample divider, yaw difference and the oscillation phase sequence.
// ---------------------------------------------------------------------------
module yosd_track #(
    parameter int ANGLE_WIDTH = 32,
    parameter int TICK_WIDTH  = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  yosd_pkg::item_t     item,
    input  yosd_pkg::cfg_t      cfg,
    output yosd_pkg::result_t   result
);

    localparam int AW = ANGLE_WIDTH;
    localparam int TW = TICK_WIDTH;
    localparam int WW = (AW > 32) ? AW : 32;
    localparam int CW = ((AW > 17) ? AW : 17) + 1;
    localparam logic [TW-1:0] DEADLINE_RST = TW'(yosd_pkg::RST_LONG_TIMEOUT);

    logic [TW-1:0]          tick_reg,     tick_next;
    logic [TW-1:0]          deadline_reg, deadline_next;
    logic [15:0]            lost_reg,     lost_next;
    logic [15:0]            sphase_reg,   sphase_next;
    yosd_pkg::phase_t       phase_reg,    phase_next;
    logic [3:0]             confirm_reg,  confirm_next;
    logic signed [AW-1:0]   last_yaw_reg, last_yaw_next;

    logic signed [WW-1:0]   yaw_w;
    logic signed [AW-1:0]   yaw_a;
    logic signed [AW:0]     diff_full;
    logic signed [AW-1:0]   diff;
    logic signed [CW-1:0]   diff_c, big_c, small_c;
    logic [TW-1:0]          tick_inc;
    logic [TW:0]            short_sum, long_sum;
    logic [TW-1:0]          short_dl, long_dl;
    logic [16:0]            sphase_sum;

    // Bring the yaw to the angle width
    assign yaw_w = WW'(item.yaw_angle);
    assign yaw_a = yaw_w[AW-1:0];

    // Saturating yaw difference against the last sample
    assign diff_full = {yaw_a[AW-1], yaw_a} - {last_yaw_reg[AW-1], last_yaw_reg};
    always_comb begin
        if (diff_full[AW] != diff_full[AW-1]) begin
            diff = diff_full[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end else begin
            diff = diff_full[AW-1:0];
        end
    end

    assign diff_c  = CW'(diff);
    assign big_c   = CW'(cfg.big_threshold);
    assign small_c = CW'(cfg.small_threshold);

    // Saturating tick counter and deadlines relative to it
    assign tick_inc  = (tick_reg == '1) ? tick_reg : tick_reg + TW'(1);
    assign short_sum = {1'b0, tick_inc} + (TW+1)'(cfg.short_timeout);
    assign long_sum  = {1'b0, tick_inc} + (TW+1)'(cfg.long_timeout);
    assign short_dl  = short_sum[TW] ? '1 : short_sum[TW-1:0];
    assign long_dl   = long_sum[TW]  ? '1 : long_sum[TW-1:0];

    assign sphase_sum = {1'b0, sphase_reg} + 17'd1;

    // Work out the next state for one tick
    always_comb begin
        yosd_pkg::phase_t p;
        logic             hit;

        tick_next     = tick_reg;
        deadline_next = deadline_reg;
        lost_next     = lost_reg;
        sphase_next   = sphase_reg;
        phase_next    = phase_reg;
        confirm_next  = confirm_reg;
        last_yaw_next = last_yaw_reg;
        p             = phase_reg;
        hit           = 1'b0;

        if (step) begin
            if (item.enable) begin
                tick_next = tick_inc;
                if (item.target_seen) begin
                    lost_next = '0;
                end else if (lost_reg != yosd_pkg::LOST_MAX) begin
                    lost_next = lost_reg + 16'd1;
                end

                if (sphase_sum >= {1'b0, cfg.sample_period}) begin
                    sphase_next = '0;
                    if (lost_next < cfg.lost_limit) begin
                        // Start a check on a large swing
                        if (p == yosd_pkg::PH_IDLE) begin
                            if (diff_c > big_c) begin
                                p             = yosd_pkg::PH_POS_SWING;
                                deadline_next = short_dl;
                            end else if (diff_c < -big_c) begin
                                p             = yosd_pkg::PH_NEG_SWING;
                                deadline_next = short_dl;
                            end
                        end

                        // Count confirming small changes
                        unique case (p)
                            yosd_pkg::PH_POS_SWING, yosd_pkg::PH_POS_SECOND:
                                hit = diff_c < -small_c;
                            yosd_pkg::PH_NEG_SWING, yosd_pkg::PH_NEG_SECOND:
                                hit = diff_c > small_c;
                            default:
                                hit = 1'b0;
                        endcase
                        if (hit) begin
                            if (confirm_next != yosd_pkg::CONFIRM_MAX) begin
                                confirm_next = confirm_next + 4'd1;
                            end
                            deadline_next = short_dl;
                        end

                        // Advance when a confirm phase is complete
                        if (confirm_next >= cfg.confirm_count) begin
                            unique case (p)
                                yosd_pkg::PH_POS_SWING: begin
                                    p            = yosd_pkg::PH_POS_SECOND;
                                    confirm_next = '0;
                                end
                                yosd_pkg::PH_NEG_SWING: begin
                                    p            = yosd_pkg::PH_NEG_SECOND;
                                    confirm_next = '0;
                                end
                                yosd_pkg::PH_POS_SECOND, yosd_pkg::PH_NEG_SECOND: begin
                                    p             = yosd_pkg::PH_SPIN;
                                    confirm_next  = '0;
                                    deadline_next = long_dl;
                                end
                                default: begin
                                    p = p;
                                end
                            endcase
                        end

                        // Drop back to idle past the deadline
                        if (p != yosd_pkg::PH_IDLE && tick_inc > deadline_next) begin
                            p = yosd_pkg::PH_IDLE;
                        end

                        phase_next    = p;
                        last_yaw_next = yaw_a;
                    end
                end else begin
                    sphase_next = sphase_sum[15:0];
                end
            end else begin
                tick_next     = '0;
                sphase_next   = '0;
                deadline_next = TW'(cfg.long_timeout);
            end
        end
    end

    // Result of this tick
    assign result.phase       = phase_next;
    assign result.spinning    = (phase_next == yosd_pkg::PH_SPIN);
    assign result.target_lost = (lost_next >= cfg.lost_limit);

    // Hold the detector state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg     <= '0;
            deadline_reg <= DEADLINE_RST;
            lost_reg     <= '0;
            sphase_reg   <= '0;
            phase_reg    <= yosd_pkg::PH_IDLE;
            confirm_reg  <= '0;
            last_yaw_reg <= '0;
        end else begin
            tick_reg     <= tick_next;
            deadline_reg <= deadline_next;
            lost_reg     <= lost_next;
            sphase_reg   <= sphase_next;
            phase_reg    <= phase_next;
            confirm_reg  <= confirm_next;
            last_yaw_reg <= last_yaw_next;
        end
    end

endmodule

// ----- hw/rtl/yaw_oscillation_spin_detector.sv -----
// ---------------------------------------------------------------------------
// yaw_oscillation_spin_detector
// Detects a spinning target from the oscillation of the cumulative yaw angle
// sampled at a fixed tick period. One result transaction per input tick.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  s_       | in        | s_valid / s_ready      | s_item   (yosd_pkg::item_t)
//  m_       | out       | m_valid / m_ready      | m_result (yosd_pkg::result_t)
//  cfg_     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One tick per cycle sustained while m_ready holds; an accepted tick passes
//  through the input register, then the result register, before it is shown.
//  The state update is a single pass of compares and saturating adds.
//  Reset (aresetn low, synchronous) clears both stages and loads the
//  register defaults; no clearing pass is needed.
//  A stalled result holds the result register; the input register still
//  takes one more tick, and s_ready drops only when both are full.
// ---------------------------------------------------------------------------
module yaw_oscillation_spin_detector #(
    parameter int ANGLE_WIDTH = 32,
    parameter int TICK_WIDTH  = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  yosd_pkg::item_t     s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output yosd_pkg::result_t   m_result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    yosd_pkg::cfg_t     cfg;
    yosd_pkg::item_t    in_reg;
    logic               in_valid_reg;
    yosd_pkg::result_t  out_reg;
    logic               out_valid_reg;
    yosd_pkg::result_t  step_result;
    logic               advance;

    // Register file
    yosd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Move a tick from the input register to the result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    yosd_track #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .TICK_WIDTH  (TICK_WIDTH)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

`ifndef SYNTHESIS
    // Spinning flag agrees with the phase code
    a_spin_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result.spinning == (m_result.phase == yosd_pkg::PH_SPIN)))
        else $error("spinning flag disagrees with phase");

    // Phase code stays within the defined phases
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result.phase <= yosd_pkg::PH_SPIN))
        else $error("phase code out of range");

    // A tick moved on always shows up as a result next cycle
    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced tick produced no result");

    // A held tick in the input register is not overwritten
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_reg)))
        else $error("input register overwritten while held");

    // Input side stalls only when both stages are occupied
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled with room available");
`endif

endmodule

// ----- sim/yosd_checker.sv -----
// ---------------------------------------------------------------------------
// yosd_checker
// Watches the tick, result and register channels of the yaw oscillation spin
// detector, keeps its own model of the detection state and compares every
// result transaction against the oldest predicted status.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module yosd_checker
    import yosd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  item_t       s_item,
    input  logic        m_valid,
    input  logic        m_ready,
    input  result_t     m_result,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          result_count,
    output int          spin_count,
    output int          lost_flag_count
);

    localparam int     MAX_REPORTS = 10;
    localparam longint ANGLE_MAX   = 64'sd2147483647;
    localparam longint ANGLE_MIN   = -ANGLE_MAX - 1;

    // Shadow registers and detection state
    cfg_t               settings;
    logic [31:0]        ticks;
    logic [31:0]        deadline;
    logic [15:0]        missing_ticks;
    logic [15:0]        sample_ctr;
    phase_t             phase;
    logic [3:0]         confirm_ctr;
    logic signed [31:0] prev_yaw;

    result_t            expected_status [$];

    function automatic logic [31:0] deadline_after(logic [15:0] span);
        logic [32:0] total;
        total = {1'b0, ticks} + {17'b0, span};
        return total[32] ? 32'hFFFF_FFFF : total[31:0];
    endfunction

    // Count one confirming change and push the short deadline out
    function automatic void note_change(logic hit);
        if (hit) begin
            if (confirm_ctr != CONFIRM_MAX)
                confirm_ctr++;
            deadline = deadline_after(settings.short_timeout);
        end
    endfunction

    // Compare the yaw with the previous sample and advance the phase
    function automatic void take_yaw_sample(logic signed [31:0] yaw);
        longint swing;
        longint big;
        longint minor;
        phase_t p;
        swing = longint'(yaw) - longint'(prev_yaw);
        if (swing > ANGLE_MAX) swing = ANGLE_MAX;
        if (swing < ANGLE_MIN) swing = ANGLE_MIN;
        big   = longint'(settings.big_threshold);
        minor = longint'(settings.small_threshold);
        p     = phase;

        if (p == PH_IDLE) begin
            if (swing > big) begin
                p = PH_POS_SWING;
                deadline = deadline_after(settings.short_timeout);
            end
            if (swing < -big) begin
                p = PH_NEG_SWING;
                deadline = deadline_after(settings.short_timeout);
            end
        end
        if (p == PH_NEG_SECOND) begin
            note_change(swing > minor);
            if (confirm_ctr >= settings.confirm_count) begin
                p = PH_SPIN;
                confirm_ctr = '0;
                deadline = deadline_after(settings.long_timeout);
            end
        end
        if (p == PH_NEG_SWING) begin
            note_change(swing > minor);
            if (confirm_ctr >= settings.confirm_count) begin
                p = PH_NEG_SECOND;
                confirm_ctr = '0;
            end
        end
        if (p == PH_POS_SECOND) begin
            note_change(swing < -minor);
            if (confirm_ctr >= settings.confirm_count) begin
                p = PH_SPIN;
                confirm_ctr = '0;
                deadline = deadline_after(settings.long_timeout);
            end
        end
        if (p == PH_POS_SWING) begin
            note_change(swing < -minor);
            if (confirm_ctr >= settings.confirm_count) begin
                p = PH_POS_SECOND;
                confirm_ctr = '0;
            end
        end
        // Deadlines are only looked at on sampling ticks
        if (p != PH_IDLE && ticks > deadline)
            p = PH_IDLE;
        phase    = p;
        prev_yaw = yaw;
    endfunction

    // Advance the model by one tick and return the status it shows
    function automatic result_t advance_tick(item_t it);
        result_t    status;
        logic [16:0] next_ctr;
        if (it.enable) begin
            if (ticks != 32'hFFFF_FFFF)
                ticks++;
            if (it.target_seen)
                missing_ticks = '0;
            else if (missing_ticks != LOST_MAX)
                missing_ticks++;
            next_ctr = {1'b0, sample_ctr} + 17'd1;
            if (next_ctr >= {1'b0, settings.sample_period}) begin
                sample_ctr = '0;
                if (missing_ticks < settings.lost_limit)
                    take_yaw_sample(it.yaw_angle);
            end else begin
                sample_ctr = next_ctr[15:0];
            end
        end else begin
            ticks      = '0;
            sample_ctr = '0;
            deadline   = {16'b0, settings.long_timeout};
        end
        status.phase       = phase;
        status.spinning    = (phase == PH_SPIN);
        status.target_lost = (missing_ticks >= settings.lost_limit);
        return status;
    endfunction

    function automatic void write_register(logic [2:0] idx, logic [15:0] value);
        case (cfg_index_t'(idx))
            CFG_SAMPLE_PERIOD:   settings.sample_period   = value;
            CFG_BIG_THRESHOLD:   settings.big_threshold   = value;
            CFG_SMALL_THRESHOLD: settings.small_threshold = value;
            CFG_SHORT_TIMEOUT:   settings.short_timeout   = value;
            CFG_LONG_TIMEOUT:    settings.long_timeout    = value;
            CFG_LOST_LIMIT:      settings.lost_limit      = value;
            CFG_CONFIRM_COUNT:   settings.confirm_count   = value[3:0];
            default: ;
        endcase
    endfunction

    // Track the channels on every rising edge
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            settings.sample_period   = RST_SAMPLE_PERIOD;
            settings.big_threshold   = RST_BIG_THRESHOLD;
            settings.small_threshold = RST_SMALL_THRESHOLD;
            settings.short_timeout   = RST_SHORT_TIMEOUT;
            settings.long_timeout    = RST_LONG_TIMEOUT;
            settings.lost_limit      = RST_LOST_LIMIT;
            settings.confirm_count   = RST_CONFIRM_COUNT;
            ticks         = '0;
            deadline      = {16'b0, RST_LONG_TIMEOUT};
            missing_ticks = '0;
            sample_ctr    = '0;
            phase         = PH_IDLE;
            confirm_ctr   = '0;
            prev_yaw      = '0;
            expected_status.delete();
        end else begin
            // Check the result transaction before queueing a new prediction
            if (m_valid && m_ready) begin
                result_count++;
                if (m_result.spinning)    spin_count++;
                if (m_result.target_lost) lost_flag_count++;
                if (expected_status.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result phase %0d spinning %0b lost %0b",
                                 $time, m_result.phase, m_result.spinning,
                                 m_result.target_lost);
                end else begin
                    want = expected_status.pop_front();
                    if (m_result.phase !== want.phase
                            || m_result.spinning !== want.spinning
                            || m_result.target_lost !== want.target_lost) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: result mismatch: expected phase %0d spinning %0b lost %0b, got phase %0d spinning %0b lost %0b",
                                     $time, want.phase, want.spinning, want.target_lost,
                                     m_result.phase, m_result.spinning,
                                     m_result.target_lost);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            if (s_valid && s_ready)
                expected_status.push_back(advance_tick(s_item));
        end
        pending = expected_status.size();
    end

endmodule

// ----- sim/yaw_oscillation_spin_detector_test.sv -----
// ---------------------------------------------------------------------------
// yaw_oscillation_spin_detector_test
// Drives tick transactions and register writes into the spin detector under
// several register settings and pacing modes; a checker beside the block
// predicts every status and the top reports the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module yaw_oscillation_spin_detector_test;
    import yosd_pkg::*;

    localparam int RESULT_LATENCY = 2;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PHASE_TICKS    = 275;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    item_t       s_item    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    result_t     m_result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_SAMPLE_PERIOD;
    logic [15:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int result_count;
    int spin_count;
    int lost_flag_count;

    int                 send_gap_pct   = 0;
    int                 m_stall_pct    = 0;
    int                 ticks_sent     = 0;
    int                 settings_count = 0;
    logic signed [31:0] cur_yaw        = '0;
    int                 yaw_steps [$];

    yaw_oscillation_spin_detector uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    yosd_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result        (m_result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .result_count    (result_count),
        .spin_count      (spin_count),
        .lost_flag_count (lost_flag_count)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Stall the result channel at random when asked
    always @(negedge aclk)
        m_ready <= (m_stall_pct == 0) || ($urandom_range(99) >= m_stall_pct);

    // Hard stop on a hung handshake
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("cycle limit of %0d reached with %0d results outstanding",
                 CYCLE_LIMIT, pending);
        $display("** yaw_oscillation_spin_detector: FAILED **");
        $finish;
    end

    function automatic item_t tick_item(logic en, logic seen, logic signed [31:0] yaw);
        item_t it;
        it.enable      = en;
        it.target_seen = seen;
        it.yaw_angle   = yaw;
        return it;
    endfunction

    function automatic logic [15:0] reg_value(cfg_t c, cfg_index_t idx);
        case (idx)
            CFG_SAMPLE_PERIOD:   return c.sample_period;
            CFG_BIG_THRESHOLD:   return c.big_threshold;
            CFG_SMALL_THRESHOLD: return c.small_threshold;
            CFG_SHORT_TIMEOUT:   return c.short_timeout;
            CFG_LONG_TIMEOUT:    return c.long_timeout;
            CFG_LOST_LIMIT:      return c.lost_limit;
            default:             return {12'b0, c.confirm_count};
        endcase
    endfunction

    function automatic void set_pacing(int mode);
        case (mode)
            1:       begin send_gap_pct = 49; m_stall_pct = 0;  end
            2:       begin send_gap_pct = 0;  m_stall_pct = 49; end
            3:       begin send_gap_pct = 35; m_stall_pct = 35; end
            default: begin send_gap_pct = 0;  m_stall_pct = 0;  end
        endcase
    endfunction

    function automatic cfg_t random_settings();
        cfg_t c;
        c.sample_period   = 16'($urandom_range(1, 4));
        c.big_threshold   = 16'($urandom_range(0, 2000));
        c.small_threshold = 16'($urandom_range(0, c.big_threshold));
        c.short_timeout   = 16'($urandom_range(2, 60));
        c.long_timeout    = 16'($urandom_range(10, 400));
        c.lost_limit      = 16'($urandom_range(2, 50));
        c.confirm_count   = 4'($urandom_range(1, 6));
        return c;
    endfunction

    function automatic cfg_t settings_for(int ph);
        cfg_t c;
        c = random_settings();
        case (ph)
            0: c = '{16'd1, 16'd120, 16'd30, 16'd200, 16'd5000, 16'd1000, 4'd3};
            1: c = '{16'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd5, 4'd1};
            2: c = '{16'd3, 16'd36000, 16'd36000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15};
            // zero period acts as one; zero confirm count finishes a phase at once
            3: c = '{16'd0, 16'd500, 16'd100, 16'd10, 16'd40, 16'd20, 4'd0};
            5: c.sample_period = 16'hFFFF;
            6: c = '{RST_SAMPLE_PERIOD, RST_BIG_THRESHOLD, RST_SMALL_THRESHOLD,
                     RST_SHORT_TIMEOUT, RST_LONG_TIMEOUT, RST_LOST_LIMIT,
                     RST_CONFIRM_COUNT};
            default: ;
        endcase
        return c;
    endfunction

    // Present one tick, with an optional idle gap first; returns after a falling edge
    task automatic send_tick(item_t it);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        ticks_sent++;
    endtask

    // Hold off until every predicted status has been checked, then let the block drain
    task automatic settle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (RESULT_LATENCY + 2) @(negedge aclk);
    endtask

    // Write all registers in index order; only called while the block is idle
    task automatic load_settings(cfg_t c);
        cfg_index_t idx;
        idx = idx.first();
        forever begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= reg_value(c, idx);
            do @(posedge aclk); while (!cfg_ready);
            @(negedge aclk);
            if (idx == idx.last())
                break;
            idx = idx.next();
        end
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // Short directed run: both swing directions, saturating differences,
    // target loss, disabled ticks and full-range yaw values
    task automatic run_directed();
        send_tick(tick_item(1'b0, 1'b1, 32'sd0));
        send_tick(tick_item(1'b1, 1'b1, 32'sd0));
        send_tick(tick_item(1'b1, 1'b1, 32'sd1000));
        send_tick(tick_item(1'b1, 1'b1, 32'sd900));
        send_tick(tick_item(1'b1, 1'b1, 32'sd850));
        send_tick(tick_item(1'b1, 1'b1, 32'sd850));
        send_tick(tick_item(1'b0, 1'b1, 32'sd850));
        send_tick(tick_item(1'b1, 1'b1, 32'h8000_0000));
        send_tick(tick_item(1'b1, 1'b1, 32'h7FFF_FFFF));
        repeat (4) send_tick(tick_item(1'b1, 1'b0, 32'sd0));
        send_tick(tick_item(1'b1, 1'b1, 32'sd0));
        send_tick(tick_item(1'b1, 1'b1, -32'sd1000));
        send_tick(tick_item(1'b1, 1'b1, -32'sd950));
        send_tick(tick_item(1'b1, 1'b1, -32'sd950));
        send_tick(tick_item(1'b1, 1'b1, -32'sd900));
        send_tick(tick_item(1'b1, 1'b1, $urandom));
        send_tick(tick_item(1'b0, 1'b0, $urandom));
        send_tick(tick_item(1'b1, 1'b0, $urandom));
        send_tick(tick_item(1'b1, 1'b1, ~s_item.yaw_angle));
    endtask

    // Queue one oscillation: a large swing, then mostly opposite small changes
    function automatic void plan_swing(cfg_t c);
        int dir;
        int minor;
        dir = $urandom_range(1) ? 1 : -1;
        yaw_steps.push_back(dir * (int'(c.big_threshold) + 1 + $urandom_range(0, 300)));
        for (int k = 0; k < 2 * c.confirm_count + 2; k++) begin
            minor = int'(c.small_threshold) + 1 + $urandom_range(0, 150);
            case ($urandom_range(9))
                8:       yaw_steps.push_back(0);
                9:       yaw_steps.push_back(dir * minor);
                default: yaw_steps.push_back(-dir * minor);
            endcase
        end
    endfunction

    // Random run built from held yaw levels, most held for one sampling interval
    task automatic run_random(cfg_t c, int count, bit pause_midway);
        int  left;
        int  span;
        int  period;
        int  choice;
        bit  missing;
        left   = count;
        period = (c.sample_period == 0) ? 1 : int'(c.sample_period);
        while (left > 0) begin
            missing = 1'b0;
            if ($urandom_range(99) < 8) begin
                // stretch without a target
                missing = 1'b1;
                span = $urandom_range(1, (c.lost_limit > 36) ? 40 : c.lost_limit + 4);
            end else begin
                if (yaw_steps.size() == 0) begin
                    choice = $urandom_range(99);
                    if (choice < 65)
                        plan_swing(c);
                    else if (choice < 80)
                        yaw_steps.push_back(($urandom_range(1) ? 1 : -1)
                                            * int'($urandom_range(0, 2 * c.big_threshold + 200)));
                    else if (choice < 90)
                        yaw_steps.push_back(0);
                    else if (choice < 96)
                        cur_yaw = $urandom;
                    else
                        cur_yaw = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                end
                if (yaw_steps.size() != 0)
                    cur_yaw = cur_yaw + yaw_steps.pop_front();
                if (period > 40)
                    span = $urandom_range(1, 40);
                else if ($urandom_range(99) < 85)
                    span = period;
                else
                    span = $urandom_range(1, 2 * period);
            end
            for (int k = 0; k < span && left > 0; k++) begin
                send_tick(tick_item($urandom_range(99) >= 3,
                                    missing ? ($urandom_range(99) < 3)
                                            : ($urandom_range(99) >= 2),
                                    cur_yaw));
                left--;
                if (pause_midway && left == count / 2)
                    settle();
            end
        end
    endtask

    initial begin
        cfg_t c;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_pacing(0);
        load_settings('{16'd1, 16'd120, 16'd30, 16'd200, 16'd2, 16'd3, 4'd1});
        run_directed();
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            c = settings_for(ph);
            set_pacing(ph % 4);
            load_settings(c);
            run_random(c, (ph == 5) ? 30 : PHASE_TICKS, ph == 2);
            settle();
        end

        $display("Sent %0d ticks under %0d register settings and four pacing modes.",
                 ticks_sent, settings_count);
        $display("Checked %0d results: %0d spinning, %0d target lost, %0d failures.",
                 result_count, spin_count, lost_flag_count, fail_count);
        if (fail_count == 0)
            $display("** yaw_oscillation_spin_detector: PASSED **");
        else
            $display("** yaw_oscillation_spin_detector: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/yosd_pkg.sv
hw/rtl/yosd_cfg.sv
hw/rtl/yosd_track.sv
hw/rtl/yaw_oscillation_spin_detector.sv
sim/yosd_checker.sv
sim/yaw_oscillation_spin_detector_test.sv
